// ----- rtl/wcps_pkg.sv -----
// Package for the word clock phrase selector: word codes, register indexes
// and the phrase buffer type shared by the builder, emitter and top level.
// No dependencies.
package wcps_pkg;

    localparam int MAX_WORDS = 12;
    localparam int CNT_W     = 4;

    typedef logic [5:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One decoded phrase: the word codes in order and how many are used.
    typedef struct packed {
        word_t [MAX_WORDS-1:0] codes;
        cnt_t                  count;
    } phrase_t;

    localparam word_t W_IT         = 6'd0;
    localparam word_t W_IS         = 6'd1;
    localparam word_t W_MID_NIGHT  = 6'd2;
    localparam word_t W_NOON       = 6'd3;
    localparam word_t W_O_CLOCK    = 6'd4;
    localparam word_t W_HALF       = 6'd5;
    localparam word_t W_PAST       = 6'd6;
    localparam word_t W_TO         = 6'd7;
    localparam word_t W_EL         = 6'd8;
    localparam word_t W_AT         = 6'd9;
    localparam word_t W_NIGHT      = 6'd10;
    localparam word_t W_IN         = 6'd11;
    localparam word_t W_THE        = 6'd12;
    localparam word_t W_MORN       = 6'd13;
    localparam word_t W_AFTER_NOON = 6'd14;
    localparam word_t W_EVE        = 6'd15;
    localparam word_t W_AND        = 6'd16;
    localparam word_t W_COLD       = 6'd17;
    localparam word_t W_COOL       = 6'd18;
    localparam word_t W_WARM       = 6'd19;
    localparam word_t W_HOT        = 6'd20;
    localparam word_t W_NUM_BASE   = 6'd20;
    localparam word_t W_HOUR_BASE  = 6'd40;

    localparam logic [1:0] REG_COLD_LIMIT = 2'd0;
    localparam logic [1:0] REG_COOL_LIMIT = 2'd1;
    localparam logic [1:0] REG_WARM_LIMIT = 2'd2;

    localparam logic signed [7:0] COLD_LIMIT_RST = 8'sd16;
    localparam logic signed [7:0] COOL_LIMIT_RST = 8'sd20;
    localparam logic signed [7:0] WARM_LIMIT_RST = 8'sd30;

endpackage

// ----- rtl/wcps_phrase.sv -----
// Combinational phrase builder: turns one registered time and temperature
// into the full list of word codes. Depends on wcps_pkg.
module wcps_phrase
(
    input  logic [4:0]        hour,
    input  logic [5:0]        minute,
    input  logic signed [7:0] temperature_c,
    input  logic signed [7:0] cold_limit,
    input  logic signed [7:0] cool_limit,
    input  logic signed [7:0] warm_limit,
    output wcps_pkg::phrase_t phrase
);

    logic [4:0] h;
    logic [5:0] m;
    logic [4:0] h2;
    logic [3:0] hw;
    logic [5:0] diff;

    always_comb
    begin
        h  = (hour > 5'd23) ? 5'd23 : hour;
        m  = (minute > 6'd59) ? 6'd59 : minute;
        h2 = (m > 6'd30) ? (h + 5'd1) : h;
        if (h2 == 5'd0)
        begin
            hw = 4'd12;
        end
        else if (h2 <= 5'd12)
        begin
            hw = h2[3:0];
        end
        else
        begin
            hw = 4'(h2 - 5'd12);
        end
        // Number word for the "to" side: units after twenty below 40, full count from 40.
        if (m < 6'd40)
        begin
            diff = 6'd40 - m;
        end
        else
        begin
            diff = 6'd60 - m;
        end
    end

    always_comb
    begin
        wcps_pkg::cnt_t n;
        n = '0;
        phrase.codes = '{default: wcps_pkg::W_IT};

        phrase.codes[n] = wcps_pkg::W_IT;
        n = n + 4'd1;
        phrase.codes[n] = wcps_pkg::W_IS;
        n = n + 4'd1;

        if (m == 6'd0)
        begin
            if (h == 5'd0)
            begin
                phrase.codes[n] = wcps_pkg::W_MID_NIGHT;
            end
            else if (h == 5'd12)
            begin
                phrase.codes[n] = wcps_pkg::W_NOON;
            end
            else
            begin
                phrase.codes[n] = wcps_pkg::W_O_CLOCK;
            end
            n = n + 4'd1;
        end
        else
        begin
            if (m <= 6'd20)
            begin
                phrase.codes[n] = wcps_pkg::W_NUM_BASE + m;
                n = n + 4'd1;
            end
            else if (m < 6'd30)
            begin
                phrase.codes[n] = wcps_pkg::W_NUM_BASE + 6'd20;
                n = n + 4'd1;
                phrase.codes[n] = m;
                n = n + 4'd1;
            end
            else if (m == 6'd30)
            begin
                phrase.codes[n] = wcps_pkg::W_HALF;
                n = n + 4'd1;
            end
            else if (m < 6'd40)
            begin
                phrase.codes[n] = wcps_pkg::W_NUM_BASE + 6'd20;
                n = n + 4'd1;
                phrase.codes[n] = wcps_pkg::W_NUM_BASE + diff;
                n = n + 4'd1;
            end
            else
            begin
                phrase.codes[n] = wcps_pkg::W_NUM_BASE + diff;
                n = n + 4'd1;
            end
            phrase.codes[n] = (m <= 6'd30) ? wcps_pkg::W_PAST : wcps_pkg::W_TO;
            n = n + 4'd1;
        end

        // The hour and part of day are skipped only on exact midnight or noon.
        if (!(m == 6'd0 && (h == 5'd0 || h == 5'd12)))
        begin
            phrase.codes[n] = wcps_pkg::W_HOUR_BASE + {2'b00, hw};
            n = n + 4'd1;
            if (h2 == 5'd11 || h2 == 5'd23)
            begin
                phrase.codes[n] = wcps_pkg::W_EL;
                n = n + 4'd1;
            end
            if (h < 5'd6 || h >= 5'd22)
            begin
                phrase.codes[n] = wcps_pkg::W_AT;
                n = n + 4'd1;
                phrase.codes[n] = wcps_pkg::W_NIGHT;
                n = n + 4'd1;
            end
            else
            begin
                phrase.codes[n] = wcps_pkg::W_IN;
                n = n + 4'd1;
                phrase.codes[n] = wcps_pkg::W_THE;
                n = n + 4'd1;
                if (h < 5'd12)
                begin
                    phrase.codes[n] = wcps_pkg::W_MORN;
                end
                else if (h < 5'd18)
                begin
                    phrase.codes[n] = wcps_pkg::W_AFTER_NOON;
                end
                else
                begin
                    phrase.codes[n] = wcps_pkg::W_EVE;
                end
                n = n + 4'd1;
            end
        end

        phrase.codes[n] = wcps_pkg::W_AND;
        n = n + 4'd1;
        if (temperature_c <= cold_limit)
        begin
            phrase.codes[n] = wcps_pkg::W_COLD;
        end
        else if (temperature_c <= cool_limit)
        begin
            phrase.codes[n] = wcps_pkg::W_COOL;
        end
        else if (temperature_c <= warm_limit)
        begin
            phrase.codes[n] = wcps_pkg::W_WARM;
        end
        else
        begin
            phrase.codes[n] = wcps_pkg::W_HOT;
        end
        n = n + 4'd1;
        phrase.count = n;
    end

endmodule

// ----- rtl/wcps_emit.sv -----
// Phrase buffer and word emitter: holds one built phrase and hands out
// its words one per handshake. Depends on wcps_pkg.
module wcps_emit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  wcps_pkg::phrase_t phrase,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [5:0]        word_code,
    output logic              last_word
);

    logic                  ph_valid_reg, ph_valid_next;
    wcps_pkg::cnt_t        idx_reg, idx_next;
    wcps_pkg::cnt_t        cnt_reg;
    wcps_pkg::word_t [wcps_pkg::MAX_WORDS-1:0] codes_reg;
    logic                  take;
    logic                  done;

    assign out_valid = ph_valid_reg;
    assign word_code = codes_reg[idx_reg];
    assign last_word = (idx_reg == cnt_reg - 4'd1);
    assign take      = ph_valid_reg && !out_stall;
    assign done      = take && last_word;
    assign free      = !ph_valid_reg || done;

    always_comb
    begin
        ph_valid_next = ph_valid_reg;
        idx_next      = idx_reg;
        if (load)
        begin
            ph_valid_next = 1'b1;
            idx_next      = '0;
        end
        else if (done)
        begin
            ph_valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_valid_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            ph_valid_reg <= ph_valid_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            codes_reg <= phrase.codes;
            cnt_reg   <= phrase.count;
        end
    end

    // A held phrase always has between five and twelve words.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_valid_reg |-> (cnt_reg >= 4'd5 && cnt_reg <= 4'd12))
        else $error("phrase word count out of range");

    // The word pointer never runs past the end of the phrase.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ph_valid_reg |-> (idx_reg < cnt_reg))
        else $error("word pointer past end of phrase");

    // Every new phrase starts with the word it.
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid && idx_reg == '0 && word_code == wcps_pkg::W_IT))
        else $error("phrase does not start with it");

    // A word taken before the last keeps the phrase on the output.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_word) |=> out_valid)
        else $error("phrase dropped before its last word");

endmodule

// ----- rtl/word_clock_phrase_select.sv -----
// Top level of the word clock phrase selector: input register, limit
// registers, phrase builder and word emitter. Depends on wcps_pkg,
// wcps_phrase and wcps_emit.
//
// Each accepted item on the input channel (hour, minute, temperature) yields
// a phrase of 5 to 12 output words, one word per cycle on the output
// channel unless out_stall holds it, the final one flagged by last_word. The
// first word is shown once the item has passed through the input register
// and been loaded into the phrase buffer. The input register holds the next
// item while the current phrase drains, so a new item can be accepted before
// the last one is through, and that item's phrase is built and loaded in the
// same cycle the last word of the previous phrase is taken, so phrases
// follow each other with no gap. Hours above 23 and minutes above 59 are
// treated as 23 and 59. The user must write the three temperature limits
// through cfg_we/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this. An index of three is ignored.
module word_clock_phrase_select
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [4:0]        hour,
    input  logic [5:0]        minute,
    input  logic signed [7:0] temperature_c,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [5:0]        word_code,
    output logic              last_word
);

    logic                    in_full_reg, in_full_next;
    logic [4:0]              hour_reg;
    logic [5:0]              minute_reg;
    logic signed [7:0]       temp_reg;
    logic signed [7:0]       cold_limit_reg;
    logic signed [7:0]       cool_limit_reg;
    logic signed [7:0]       warm_limit_reg;
    logic                    emit_free;
    logic                    load;
    logic                    in_take;
    wcps_pkg::phrase_t       phrase;

    // The held item moves into the phrase buffer as soon as it is free.
    assign load     = in_full_reg && emit_free;
    assign in_stall = in_full_reg && !load;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (load)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hour_reg   <= hour;
            minute_reg <= minute;
            temp_reg   <= temperature_c;
        end
    end

    // Limit registers come out of reset at their documented defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cold_limit_reg <= wcps_pkg::COLD_LIMIT_RST;
            cool_limit_reg <= wcps_pkg::COOL_LIMIT_RST;
            warm_limit_reg <= wcps_pkg::WARM_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wcps_pkg::REG_COLD_LIMIT: cold_limit_reg <= cfg_data;
                wcps_pkg::REG_COOL_LIMIT: cool_limit_reg <= cfg_data;
                wcps_pkg::REG_WARM_LIMIT: warm_limit_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    wcps_phrase u_phrase
    (
        .hour          (hour_reg),
        .minute        (minute_reg),
        .temperature_c (temp_reg),
        .cold_limit    (cold_limit_reg),
        .cool_limit    (cool_limit_reg),
        .warm_limit    (warm_limit_reg),
        .phrase        (phrase)
    );

    wcps_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .phrase    (phrase),
        .free      (emit_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_code (word_code),
        .last_word (last_word)
    );

    // A phrase is only loaded while the input register holds an item.
    a_load_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> in_full_reg)
        else $error("phrase loaded without a held item");

    // An item is never taken while another one waits without moving on.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !load) |-> !in_take)
        else $error("held item overwritten");

    // After a load the output channel is busy with the new phrase.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded phrase not shown on output");

endmodule
